// ===== rtl/eaed_pkg.sv =====
`timescale 1ns / 1ps

package eaed_pkg;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_START_PERIOD     = 3'd0,
      CSR_ESCALATE_AFTER   = 3'd1,
      CSR_MIN_PERIOD       = 3'd2,
      CSR_SCAN_DIVIDE      = 3'd3,
      CSR_SCANS_PER_SECOND = 3'd4
   } csr_index_type;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   // Reset values of the configuration registers.
   localparam logic [15:0] START_PERIOD_RESET     = 16'd399;
   localparam logic [15:0] ESCALATE_AFTER_RESET   = 16'd4999;
   localparam logic [15:0] MIN_PERIOD_RESET       = 16'd75;
   localparam logic [4:0]  SCAN_DIVIDE_RESET      = 5'd10;
   localparam logic [6:0]  SCANS_PER_SECOND_RESET = 7'd100;

   // Reset values of the buzzer state.
   localparam logic [15:0] PWM_PERIOD_RESET  = 16'd399;
   localparam logic [15:0] PWM_COMPARE_RESET = 16'd199;

   // Display constants.
   localparam logic [3:0] DIGIT_NINE      = 4'd9;
   localparam logic [4:0] SCAN_DIVIDE_MAX = 5'd16;
   localparam logic [6:0] SEGMENTS_BLANK  = 7'h7F;
   localparam logic [1:0] ENABLE_ONES     = 2'b01;
   localparam logic [1:0] ENABLE_TENS     = 2'b10;

   // Command codes of an input word.
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_RISK = 1'b1;

   typedef struct packed {
      logic       command;
      logic [7:0] risk_byte;
   } req_word_type;

   typedef struct packed {
      logic        buzzer_level;
      logic [6:0]  segment_lines;
      logic [1:0]  digit_enable;
      logic [15:0] current_period;
      logic [6:0]  seconds_shown;
      logic        alarm_on;
   } rsp_word_type;

   // Active-low segment pattern for one BCD digit; codes above nine are blank.
   function automatic logic [6:0] segment_code(input logic [3:0] digit);
      logic [6:0] lit;
      case (digit)
         4'd0:    lit = 7'h3F;
         4'd1:    lit = 7'h06;
         4'd2:    lit = 7'h5B;
         4'd3:    lit = 7'h4F;
         4'd4:    lit = 7'h66;
         4'd5:    lit = 7'h6D;
         4'd6:    lit = 7'h7D;
         4'd7:    lit = 7'h07;
         4'd8:    lit = 7'h7F;
         4'd9:    lit = 7'h6F;
         default: lit = 7'h00;
      endcase
      return ~lit;
   endfunction

endpackage

// ===== rtl/escalating_alarm_with_elapsed_display_core.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Word
// req      in         req_valid/req_ready  req_data  (command, risk_byte)
// rsp      out        rsp_valid/rsp_ready  rsp_data  (buzzer, display, period, seconds)
// csr      in         csr_write_enable     csr_index, csr_write_data
//
// One word is taken every cycle unless the result stalls; its result goes through the input
// register, then the state update and result register, which are loaded together.
// The next-state logic is combinational and includes one 16 x 17 multiply and compare for
// the escalation check.
// A stalled result holds the result register; one more word waits in the input register.
// Synchronous reset clears the valid flags, resets the alarm state and restores the register defaults.
module escalating_alarm_with_elapsed_display_core
   import eaed_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_word_type               req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_word_type               rsp_data,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   // Configuration registers.
   logic [15:0] start_period_ff;
   logic [15:0] escalate_after_ff;
   logic [15:0] min_period_ff;
   logic [4:0]  scan_divide_ff;
   logic [6:0]  scans_per_second_ff;

   // Pipeline registers.
   logic         in_valid_ff;
   req_word_type in_word_ff;
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;
   rsp_word_type rsp_word_in;
   logic         advance;

   // Alarm state.
   logic [7:0]  risk_level_ff,     risk_level_in;
   logic [15:0] pwm_count_ff,      pwm_count_in;
   logic [15:0] pwm_period_ff,     pwm_period_in;
   logic [15:0] pwm_compare_ff,    pwm_compare_in;
   logic        buzzer_en_ff,      buzzer_en_in;
   logic [15:0] period_tally_ff,   period_tally_in;
   logic        scan_en_ff,        scan_en_in;
   logic [3:0]  scan_prescale_ff,  scan_prescale_in;
   logic [6:0]  scan_tally_ff,     scan_tally_in;
   logic [3:0]  tens_ff,           tens_in;
   logic [3:0]  ones_ff,           ones_in;
   logic        show_tens_ff,      show_tens_in;
   logic [6:0]  segment_ff,        segment_in;
   logic [1:0]  enable_ff,         enable_in;

   // Helpers derived from the current state.
   logic [15:0] tally_inc;
   logic [32:0] duration;
   logic        escalate;
   logic [4:0]  divide_eff;
   logic [6:0]  sps_eff;
   logic [6:0]  scan_tally_inc;
   logic        period_wrap;
   logic        scan_due;
   logic [7:0]  tens_times_ten;

   // The stage advances whenever the input register holds a word and the result register is free or being emptied.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_period_ff     <= START_PERIOD_RESET;
         escalate_after_ff   <= ESCALATE_AFTER_RESET;
         min_period_ff       <= MIN_PERIOD_RESET;
         scan_divide_ff      <= SCAN_DIVIDE_RESET;
         scans_per_second_ff <= SCANS_PER_SECOND_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_START_PERIOD:     start_period_ff     <= csr_write_data;
            CSR_ESCALATE_AFTER:   escalate_after_ff   <= csr_write_data;
            CSR_MIN_PERIOD:       min_period_ff       <= csr_write_data;
            CSR_SCAN_DIVIDE:      scan_divide_ff      <= csr_write_data[4:0];
            CSR_SCANS_PER_SECOND: scans_per_second_ff <= csr_write_data[6:0];
            default: ;
         endcase
      end
   end

   // Period-end escalation check: saturated tally times period length.
   assign tally_inc   = (period_tally_ff != 16'hFFFF) ? period_tally_ff + 16'd1
                                                      : period_tally_ff;
   assign duration    = 33'(tally_inc) * 33'({1'b0, pwm_period_ff} + 17'd1);
   assign escalate    = (risk_level_ff == 8'd1) && (duration > 33'(escalate_after_ff))
                        && (pwm_period_ff > min_period_ff);
   assign period_wrap = (pwm_count_ff == pwm_period_ff) || (pwm_count_ff == 16'hFFFF);

   // Scan prescaler and seconds divider limits.
   assign divide_eff     = (scan_divide_ff == 5'd0) ? 5'd1 :
                           (scan_divide_ff > SCAN_DIVIDE_MAX) ? SCAN_DIVIDE_MAX
                                                              : scan_divide_ff;
   assign sps_eff        = (scans_per_second_ff == 7'd0) ? 7'd1 : scans_per_second_ff;
   assign scan_tally_inc = scan_tally_ff + 7'd1;
   assign scan_due       = ({1'b0, scan_prescale_ff} + 5'd1) >= divide_eff;

   // Next state for one word.
   always_comb begin
      risk_level_in    = risk_level_ff;
      pwm_count_in     = pwm_count_ff;
      pwm_period_in    = pwm_period_ff;
      pwm_compare_in   = pwm_compare_ff;
      buzzer_en_in     = buzzer_en_ff;
      period_tally_in  = period_tally_ff;
      scan_en_in       = scan_en_ff;
      scan_prescale_in = scan_prescale_ff;
      scan_tally_in    = scan_tally_ff;
      tens_in          = tens_ff;
      ones_in          = ones_ff;
      show_tens_in     = show_tens_ff;
      segment_in       = segment_ff;
      enable_in        = enable_ff;

      if (in_word_ff.command == CMD_RISK) begin
         // A changed risk level starts or stops the alarm.
         if (in_word_ff.risk_byte != risk_level_ff) begin
            risk_level_in   = in_word_ff.risk_byte;
            period_tally_in = 16'd0;
            if (in_word_ff.risk_byte == 8'd0) begin
               scan_en_in       = 1'b0;
               scan_prescale_in = 4'd0;
               scan_tally_in    = 7'd0;
               tens_in          = 4'd0;
               ones_in          = 4'd0;
               segment_in       = SEGMENTS_BLANK;
               enable_in        = 2'b00;
               buzzer_en_in     = 1'b0;
               pwm_compare_in   = pwm_period_ff;
            end else begin
               scan_en_in     = 1'b1;
               buzzer_en_in   = 1'b1;
               pwm_period_in  = start_period_ff;
               pwm_compare_in = {1'b0, start_period_ff[15:1]};
            end
         end
      end else begin
         // Buzzer counter and period end.
         if (period_wrap) begin
            pwm_count_in = 16'd0;
            if (escalate) begin
               period_tally_in = 16'd0;
               pwm_period_in   = {1'b0, pwm_period_ff[15:1]};
               pwm_compare_in  = {2'b00, pwm_period_ff[15:2]};
            end else begin
               period_tally_in = tally_inc;
            end
         end else begin
            pwm_count_in = pwm_count_ff + 16'd1;
         end

         // Display scan and seconds count.
         if (scan_en_ff) begin
            if (scan_due) begin
               scan_prescale_in = 4'd0;
               if (scan_tally_inc >= sps_eff) begin
                  scan_tally_in = 7'd0;
                  if (ones_ff == DIGIT_NINE) begin
                     if (tens_ff < DIGIT_NINE) begin
                        ones_in = 4'd0;
                        tens_in = tens_ff + 4'd1;
                     end
                  end else begin
                     ones_in = ones_ff + 4'd1;
                  end
               end else begin
                  scan_tally_in = scan_tally_inc;
               end
               if (show_tens_ff) begin
                  show_tens_in = 1'b0;
                  enable_in    = ENABLE_TENS;
                  segment_in   = segment_code(tens_in);
               end else begin
                  show_tens_in = 1'b1;
                  enable_in    = ENABLE_ONES;
                  segment_in   = segment_code(ones_in);
               end
            end else begin
               scan_prescale_in = scan_prescale_ff + 4'd1;
            end
         end
      end
   end

   // Result word from the updated state.
   assign tens_times_ten = {tens_in, 3'b000} + {3'b000, tens_in, 1'b0};

   always_comb begin
      rsp_word_in.buzzer_level   = buzzer_en_in && (pwm_count_in < pwm_compare_in);
      rsp_word_in.segment_lines  = segment_in;
      rsp_word_in.digit_enable   = enable_in;
      rsp_word_in.current_period = pwm_period_in;
      rsp_word_in.seconds_shown  = 7'(tens_times_ten + {4'd0, ones_in});
      rsp_word_in.alarm_on       = (risk_level_in != 8'd0);
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_word_ff <= req_data;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // State update.
   always_ff @(posedge clock) begin
      if (reset) begin
         risk_level_ff    <= 8'd0;
         pwm_count_ff     <= 16'd0;
         pwm_period_ff    <= PWM_PERIOD_RESET;
         pwm_compare_ff   <= PWM_COMPARE_RESET;
         buzzer_en_ff     <= 1'b0;
         period_tally_ff  <= 16'd0;
         scan_en_ff       <= 1'b0;
         scan_prescale_ff <= 4'd0;
         scan_tally_ff    <= 7'd0;
         tens_ff          <= 4'd0;
         ones_ff          <= 4'd0;
         show_tens_ff     <= 1'b0;
         segment_ff       <= 7'd0;
         enable_ff        <= 2'b00;
      end else if (advance) begin
         risk_level_ff    <= risk_level_in;
         pwm_count_ff     <= pwm_count_in;
         pwm_period_ff    <= pwm_period_in;
         pwm_compare_ff   <= pwm_compare_in;
         buzzer_en_ff     <= buzzer_en_in;
         period_tally_ff  <= period_tally_in;
         scan_en_ff       <= scan_en_in;
         scan_prescale_ff <= scan_prescale_in;
         scan_tally_ff    <= scan_tally_in;
         tens_ff          <= tens_in;
         ones_ff          <= ones_in;
         show_tens_ff     <= show_tens_in;
         segment_ff       <= segment_in;
         enable_ff        <= enable_in;
      end
   end

`ifndef SYNTHESIS
   // The seconds count never passes 99.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_word_ff.seconds_shown <= 7'd99))
      else $error("seconds count above 99");

   // The buzzer is silent whenever the alarm is off.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_word_ff.alarm_on) |-> !rsp_word_ff.buzzer_level)
      else $error("buzzer active with alarm off");

   // At most one digit common is driven at a time.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0(enable_ff))
      else $error("both digit commons driven");

   // A held word in the input register is not lost while the result stalls.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_word_ff)))
      else $error("pending word dropped during stall");

   // The display scan runs whenever the alarm is on.
   assert property (@(posedge clock) disable iff (reset)
      (!scan_en_ff && (risk_level_ff != 8'd0)) |-> 1'b0)
      else $error("scan disabled while alarm is on");
`endif

endmodule
